>>> rtl/core/eoac_pkg.sv
// Shared types, constants and power helpers for the extractor output afterrun control.
package eoac_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SETTINGS_VALID  = 3'd0,
      REG_SUCTION_LEVEL   = 3'd1,
      REG_FLOW_SETTING    = 3'd2,
      REG_AFTERRUN_DELAY  = 3'd3,
      REG_MIN_POWER       = 3'd4,
      REG_MAX_POWER       = 3'd5,
      REG_FIXED_ENABLE    = 3'd6,
      REG_FIXED_POWER     = 3'd7
   } csr_index_type;

   // Request kinds
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // Suction levels
   localparam logic [1:0] SUCTION_HIGH   = 2'd0;
   localparam logic [1:0] SUCTION_MEDIUM = 2'd1;
   localparam logic [1:0] SUCTION_LOW    = 2'd2;
   localparam logic [1:0] SUCTION_FLOW   = 2'd3;

   // Field widths
   localparam int POWER_W = 10;
   localparam int MASK_W  = 8;
   localparam int DELAY_W = 16;
   localparam int LEFT_W  = 26;

   // Power constants in tenths of a percent
   localparam logic [POWER_W-1:0] POWER_FULL      = 10'd1000;
   localparam logic [POWER_W-1:0] POWER_MEDIUM    = 10'd600;
   localparam logic [POWER_W-1:0] POWER_LOW       = 10'd300;
   localparam logic [POWER_W-1:0] POWER_MIN_FLOOR = 10'd1;
   localparam logic [POWER_W-1:0] FIXED_FLOOR     = 10'd100;

   // Flow rounding: (v + 5) / 10 as a multiply by 6554 / 65536
   localparam logic [10:0] FLOW_ROUND     = 11'd5;
   localparam logic [13:0] DIV10_RECIP    = 14'd6554;
   localparam logic [6:0]  FLOW_TENTHS_AT = 7'd100;
   localparam logic [6:0]  PCT_MIN        = 7'd10;
   localparam logic [6:0]  PCT_MAX        = 7'd100;
   localparam logic [POWER_W-1:0] PCT_SCALE = 10'd10;

   // Seconds to milliseconds
   localparam logic [LEFT_W-1:0] MS_PER_SEC = 26'd1000;

   // One result item
   typedef struct packed {
      logic               output_enabled;
      logic [POWER_W-1:0] output_power;
      logic               en_toggled;
      logic               pw_toggled;
      logic               afterrun_running;
      logic [LEFT_W-1:0]  afterrun_left_ms;
   } rsp_item_type;

   // Lower bound clamped to 1..1000
   function automatic logic [POWER_W-1:0] eff_min(input logic [POWER_W-1:0] minp);
      logic [POWER_W-1:0] lo;
      lo = minp;
      if (lo < POWER_MIN_FLOOR) lo = POWER_MIN_FLOOR;
      if (lo > POWER_FULL) lo = POWER_FULL;
      return lo;
   endfunction

   // Upper bound clamped to 1000 and raised to the lower bound
   function automatic logic [POWER_W-1:0] eff_max(input logic [POWER_W-1:0] minp,
                                                  input logic [POWER_W-1:0] maxp);
      logic [POWER_W-1:0] hi;
      logic [POWER_W-1:0] lo;
      lo = eff_min(minp);
      hi = maxp;
      if (hi > POWER_FULL) hi = POWER_FULL;
      if (hi < lo) hi = lo;
      return hi;
   endfunction

   // Fixed afterrun power clamped to 100..1000
   function automatic logic [POWER_W-1:0] fixed_power(input logic [POWER_W-1:0] p);
      logic [POWER_W-1:0] q;
      q = p;
      if (q < FIXED_FLOOR) q = FIXED_FLOOR;
      if (q > POWER_FULL) q = POWER_FULL;
      return q;
   endfunction

   // Target power from suction level or flow setting (full power while settings are invalid), clamped to min..max
   function automatic logic [POWER_W-1:0] demand_power(
      input logic               sv,
      input logic [1:0]         lvl,
      input logic [POWER_W-1:0] flow,
      input logic [POWER_W-1:0] minp,
      input logic [POWER_W-1:0] maxp);
      logic [POWER_W-1:0] t;
      logic [10:0]        rnd;
      logic [24:0]        prod;
      logic [6:0]         pct;
      logic [POWER_W-1:0] lo;
      logic [POWER_W-1:0] hi;
      t    = POWER_FULL;
      rnd  = {1'b0, flow} + FLOW_ROUND;
      prod = 25'(rnd) * 25'(DIV10_RECIP);
      if (flow >= POWER_W'(FLOW_TENTHS_AT)) pct = prod[22:16];
      else pct = flow[6:0];
      if (pct < PCT_MIN) pct = PCT_MIN;
      if (pct > PCT_MAX) pct = PCT_MAX;
      if (sv) begin
         case (lvl)
            SUCTION_MEDIUM: t = POWER_MEDIUM;
            SUCTION_LOW:    t = POWER_LOW;
            SUCTION_FLOW:   t = POWER_W'(pct) * PCT_SCALE;
            default:        t = POWER_FULL;
         endcase
      end
      lo = eff_min(minp);
      hi = eff_max(minp, maxp);
      if (t < lo) t = lo;
      if (t > hi) t = hi;
      return t;
   endfunction

endpackage

>>> rtl/core/extractor_output_afterrun_control.sv
// Top level of the extractor output afterrun control.
// Each request (trigger level update or millisecond tick) yields exactly one result carrying
// the fan enable, power in tenths of a percent, change flags and the afterrun countdown.
// A request is registered at the input, evaluated against the control state and written
// to a two-entry result buffer once that buffer has room, and one request is taken every
// cycle while results are drained. The input stage
// holds (req_stall high) only when that result buffer is full and a request already waits
// in the input register. Configuration writes take effect from the next request evaluated
// and cause no result of their own.
module extractor_output_afterrun_control (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [eoac_pkg::MASK_W-1:0]       req_work_mask,
   input  logic                              req_continuous_flag,
   input  logic                              req_external_active,
   input  logic                              req_automation_continuous,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_output_enabled,
   output logic [eoac_pkg::POWER_W-1:0]      rsp_output_power,
   output logic                              rsp_enable_changed,
   output logic                              rsp_power_changed,
   output logic                              rsp_afterrun_running,
   output logic [eoac_pkg::LEFT_W-1:0]       rsp_afterrun_left_ms,
   // configuration port
   input  logic                              csr_write_en,
   input  logic [eoac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [eoac_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import eoac_pkg::*;

   // Configuration registers
   logic               settings_valid_ff;
   logic [1:0]         suction_level_ff;
   logic [POWER_W-1:0] flow_setting_ff;
   logic [DELAY_W-1:0] delay_sec_ff;
   logic [POWER_W-1:0] min_power_ff;
   logic [POWER_W-1:0] max_power_ff;
   logic               fixed_enable_ff;
   logic [POWER_W-1:0] fixed_power_ff;

   // Input stage
   logic              in_valid_ff, in_valid_in;
   logic              in_type_ff;
   logic [MASK_W-1:0] in_mask_ff;
   logic              in_cont_ff, in_ext_ff, in_auto_ff;
   logic              req_accept;

   // Control state
   logic               enabled_ff, enabled_in;
   logic [POWER_W-1:0] power_ff, power_in;
   logic               afterrun_ff, afterrun_in;
   logic [LEFT_W-1:0]  remaining_ff, remaining_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               cont_ff, cont_in;
   logic               ext_ff, ext_in;
   logic               auto_ff, auto_in;

   // Result buffer
   rsp_item_type buf_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;
   rsp_item_type result;

   // Evaluation helpers
   logic               levels_differ;
   logic               trig_before;
   logic               trig_new;
   logic               trig_stored;
   logic [POWER_W-1:0] tgt;
   logic [LEFT_W-1:0]  rem_dec;

   // Handshakes
   assign push       = in_valid_ff && (count_ff != 2'd2);
   assign pop        = (count_ff != 2'd0) && !rsp_stall;
   assign req_stall  = in_valid_ff && (count_ff == 2'd2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != 2'd0);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (push) in_valid_in = 1'b0;
      if (req_accept) in_valid_in = 1'b1;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   // Evaluate the registered request against the control state
   assign levels_differ = (in_mask_ff != mask_ff) || (in_cont_ff != cont_ff) ||
                          (in_ext_ff != ext_ff) || (in_auto_ff != auto_ff);
   assign trig_before   = (mask_ff != '0) || ext_ff;
   assign trig_new      = in_cont_ff || in_auto_ff || (in_mask_ff != '0) || in_ext_ff;
   assign trig_stored   = cont_ff || auto_ff || (mask_ff != '0) || ext_ff;
   assign tgt           = demand_power(settings_valid_ff, suction_level_ff, flow_setting_ff,
                                       min_power_ff, max_power_ff);
   assign rem_dec       = (remaining_ff != '0) ? remaining_ff - 1'b1 : '0;

   always_comb begin
      enabled_in   = enabled_ff;
      power_in     = power_ff;
      afterrun_in  = afterrun_ff;
      remaining_in = remaining_ff;
      mask_in      = mask_ff;
      cont_in      = cont_ff;
      ext_in       = ext_ff;
      auto_in      = auto_ff;
      if (in_type_ff == REQ_UPDATE) begin
         if (levels_differ) begin
            mask_in = in_mask_ff;
            cont_in = in_cont_ff;
            ext_in  = in_ext_ff;
            auto_in = in_auto_ff;
            power_in = trig_new ? tgt : '0;
            if (trig_new) begin
               afterrun_in  = 1'b0;
               remaining_in = '0;
            end else if (enabled_ff && trig_before && settings_valid_ff &&
                         (delay_sec_ff != '0)) begin
               afterrun_in  = 1'b1;
               remaining_in = LEFT_W'(delay_sec_ff) * MS_PER_SEC;
            end
            if (afterrun_in) power_in = fixed_enable_ff ? fixed_power(fixed_power_ff) : tgt;
            enabled_in = trig_new || afterrun_in;
         end
      end else if (afterrun_ff) begin
         // count down; drop the output on expiry with no trigger
         remaining_in = rem_dec;
         if (rem_dec == '0) begin
            afterrun_in = 1'b0;
            if (!trig_stored && enabled_ff) begin
               enabled_in = 1'b0;
               power_in   = '0;
            end
         end
      end
   end

   // Build the result
   always_comb begin
      result.output_enabled   = enabled_in;
      result.output_power     = power_in;
      result.en_toggled       = (enabled_in != enabled_ff);
      result.pw_toggled       = (power_in != power_ff);
      result.afterrun_running = afterrun_in;
      result.afterrun_left_ms = afterrun_in ? remaining_in : '0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         count_ff          <= 2'd0;
         wr_ptr_ff         <= 1'b0;
         rd_ptr_ff         <= 1'b0;
         enabled_ff        <= 1'b0;
         power_ff          <= '0;
         afterrun_ff       <= 1'b0;
         remaining_ff      <= '0;
         mask_ff           <= '0;
         cont_ff           <= 1'b0;
         ext_ff            <= 1'b0;
         auto_ff           <= 1'b0;
         settings_valid_ff <= 1'b0;
         suction_level_ff  <= SUCTION_HIGH;
         flow_setting_ff   <= POWER_FULL;
         delay_sec_ff      <= '0;
         min_power_ff      <= POWER_MIN_FLOOR;
         max_power_ff      <= POWER_FULL;
         fixed_enable_ff   <= 1'b0;
         fixed_power_ff    <= POWER_FULL;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         if (push) begin
            wr_ptr_ff    <= !wr_ptr_ff;
            enabled_ff   <= enabled_in;
            power_ff     <= power_in;
            afterrun_ff  <= afterrun_in;
            remaining_ff <= remaining_in;
            mask_ff      <= mask_in;
            cont_ff      <= cont_in;
            ext_ff       <= ext_in;
            auto_ff      <= auto_in;
         end
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         // configuration writes
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               REG_SETTINGS_VALID: settings_valid_ff <= csr_wdata[0];
               REG_SUCTION_LEVEL:  suction_level_ff  <= csr_wdata[1:0];
               REG_FLOW_SETTING:   flow_setting_ff   <= csr_wdata[POWER_W-1:0];
               REG_AFTERRUN_DELAY: delay_sec_ff      <= csr_wdata[DELAY_W-1:0];
               REG_MIN_POWER:      min_power_ff      <= csr_wdata[POWER_W-1:0];
               REG_MAX_POWER:      max_power_ff      <= csr_wdata[POWER_W-1:0];
               REG_FIXED_ENABLE:   fixed_enable_ff   <= csr_wdata[0];
               REG_FIXED_POWER:    fixed_power_ff    <= csr_wdata[POWER_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff <= req_type;
         in_mask_ff <= req_work_mask;
         in_cont_ff <= req_continuous_flag;
         in_ext_ff  <= req_external_active;
         in_auto_ff <= req_automation_continuous;
      end
      if (push) buf_ff[wr_ptr_ff] <= result;
   end

   // Present the oldest buffered result
   assign rsp_output_enabled   = buf_ff[rd_ptr_ff].output_enabled;
   assign rsp_output_power     = buf_ff[rd_ptr_ff].output_power;
   assign rsp_enable_changed   = buf_ff[rd_ptr_ff].en_toggled;
   assign rsp_power_changed    = buf_ff[rd_ptr_ff].pw_toggled;
   assign rsp_afterrun_running = buf_ff[rd_ptr_ff].afterrun_running;
   assign rsp_afterrun_left_ms = buf_ff[rd_ptr_ff].afterrun_left_ms;

endmodule

>>> rtl/core/eoac_checker.sv
// Port-level checks for the extractor output afterrun control, bound to the top level.
module eoac_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_output_enabled,
   input logic [eoac_pkg::POWER_W-1:0]      rsp_output_power,
   input logic                              rsp_afterrun_running,
   input logic [eoac_pkg::LEFT_W-1:0]       rsp_afterrun_left_ms
);
   import eoac_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // Power is zero whenever the output is off
   a_off_power: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_output_enabled |-> rsp_output_power == '0)
      else $error("nonzero power with output off");

   // A running afterrun keeps the output on
   a_afterrun_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_afterrun_running |-> rsp_output_enabled && rsp_output_power != '0)
      else $error("afterrun without output");

   // No time left is reported without afterrun
   a_left_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_afterrun_running |-> rsp_afterrun_left_ms == '0)
      else $error("afterrun time reported while idle");

endmodule

bind extractor_output_afterrun_control eoac_checker u_eoac_checker (.*);
